### hw/rtl/ctpl_pkg.sv
`default_nettype none

package ctpl_pkg;

   // Tag width and address width of one access
   localparam int ADDR_W = 64;
   localparam int TAG_W  = 64;

   // Control register port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_L1_OFFSET   = 3'd0,
      CSR_L1_INDEX    = 3'd1,
      CSR_L1_WAYS     = 3'd2,
      CSR_L2_OFFSET   = 3'd3,
      CSR_L2_INDEX    = 3'd4,
      CSR_L2_WAYS     = 3'd5,
      CSR_L2_MODE     = 3'd6,
      CSR_L2_PREFETCH = 3'd7
   } csr_index_type;

   // L2 operating modes
   localparam logic [1:0] L2_MODE_OFF = 2'd0;
   localparam logic [1:0] L2_MODE_LIP = 2'd2;

   // Recency update kinds
   typedef enum logic {
      RANK_FRONT,
      RANK_LIP
   } rank_op_type;

   // Lookup status of one set
   typedef struct packed {
      logic hit;
      logic inv_found;
   } probe_status_type;

endpackage

`default_nettype wire

### hw/rtl/ctpl_ram.sv
`default_nettype none

module ctpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one row, register the read row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/ctpl_set_probe.sv
`default_nettype none

module ctpl_set_probe #(
   parameter int WAYS = 8,
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1,
   localparam int CW = $clog2(WAYS + 1)
) (
   input  wire logic [WAYS*ctpl_pkg::TAG_W-1:0] tags,
   input  wire logic [WAYS-1:0]                 valid,
   input  wire logic [WAYS*WW-1:0]              ranks,
   input  wire logic [CW-1:0]                   active,
   input  wire logic [ctpl_pkg::TAG_W-1:0]      tag,
   output ctpl_pkg::probe_status_type           status,
   output logic      [WW-1:0]                   hit_way,
   output logic      [WW-1:0]                   inv_way,
   output logic      [WW-1:0]                   lru_way
);

   localparam int TW = ctpl_pkg::TAG_W;

   logic [WAYS-1:0] act;
   logic [WAYS-1:0] match;
   logic [WAYS-1:0] inv;
   logic [WAYS-1:0] oldest;

   // Compare every active way of the set
   always_comb begin
      for (int j = 0; j < WAYS; j++) begin
         act[j]   = (j < int'(active));
         match[j] = act[j] && valid[j] && (tags[j*TW +: TW] == tag);
         inv[j]   = act[j] && !valid[j];
         oldest[j] = act[j];
         for (int i = 0; i < WAYS; i++) begin
            if (i != j && act[i] && (ranks[i*WW +: WW] >= ranks[j*WW +: WW])) begin
               oldest[j] = 1'b0;
            end
         end
      end
   end

   // Pick the lowest-numbered way of each kind
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      lru_way = '0;
      for (int j = WAYS - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_way = WW'(j);
         end
         if (inv[j]) begin
            inv_way = WW'(j);
         end
         if (oldest[j]) begin
            lru_way = WW'(j);
         end
      end
      status.hit       = |match;
      status.inv_found = |inv;
   end

endmodule

`default_nettype wire

### hw/rtl/ctpl_rank_update.sv
`default_nettype none

module ctpl_rank_update #(
   parameter int WAYS = 8,
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1,
   localparam int CW = $clog2(WAYS + 1)
) (
   input  wire ctpl_pkg::rank_op_type op,
   input  wire logic [WAYS*WW-1:0]    ranks_in,
   input  wire logic [WAYS-1:0]       valid_in,
   input  wire logic [CW-1:0]         active,
   input  wire logic [WW-1:0]         way,
   output logic      [WAYS*WW-1:0]    ranks_out
);

   logic [WAYS-1:0] moved;
   logic [WAYS-1:0] inv_moved;
   logic [WAYS-1:0] less;
   logic [WAYS-1:0] below;
   logic [WW-1:0]   old_w;
   logic [WW-1:0]   r;
   int              k;

   // Front: way to rank zero. LIP: way, then empty ways, to the back.
   always_comb begin
      old_w = ranks_in[int'(way)*WW +: WW];
      for (int j = 0; j < WAYS; j++) begin
         moved[j]     = (j == int'(way)) || ((j < int'(active)) && !valid_in[j]);
         inv_moved[j] = moved[j] && (j != int'(way));
      end
      k = $countones(moved);
      for (int j = 0; j < WAYS; j++) begin
         r = ranks_in[j*WW +: WW];
         for (int i = 0; i < WAYS; i++) begin
            less[i]  = moved[i] && (ranks_in[i*WW +: WW] < r);
            below[i] = inv_moved[i] && (i < j);
         end
         if (op == ctpl_pkg::RANK_FRONT) begin
            if (j == int'(way)) begin
               ranks_out[j*WW +: WW] = '0;
            end else if (r < old_w) begin
               ranks_out[j*WW +: WW] = r + WW'(1);
            end else begin
               ranks_out[j*WW +: WW] = r;
            end
         end else begin
            if (j == int'(way)) begin
               ranks_out[j*WW +: WW] = WW'(WAYS - k);
            end else if (moved[j]) begin
               ranks_out[j*WW +: WW] = WW'(WAYS - k + 1 + $countones(below));
            end else begin
               ranks_out[j*WW +: WW] = r - WW'($countones(less));
            end
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/two_level_cache_tag_policy.sv
`default_nettype none

// Two-level cache tag and replacement tracker.
// Request: pulse start with req_is_write and req_address while busy is low;
// the item is taken at that edge and busy stays high until it is done.
// Response: rsp_valid is high for one cycle with the event flags and counts;
// the receiver takes it in that cycle and cannot stall it.
// Control registers are written through csr_write_enable / csr_index /
// csr_write_data; the user must write them only while the block is idle
// (not enforced by the block); each write takes effect at once. An L1 hit
// answers from the L1 check. A miss walks the set-lookup sequencer (L1
// victim, L2 demand, prefetch probe, writeback probe, L1 fill); the L2
// demand, prefetch and writeback steps depend on the L2 mode, the prefetch
// enable and a dirty victim. Each lookup reads one whole set row from the
// L1 or L2 tag memory, each with a single read port; items do not overlap.
// Reset: a clearing pass writes empty rows with ordered ranks into every
// set of both memories, with busy high; control writes are taken during it.
module two_level_cache_tag_policy #(
   parameter int L1_MAX_SETS = 256,
   parameter int L1_MAX_WAYS = 8,
   parameter int L2_MAX_SETS = 1024,
   parameter int L2_MAX_WAYS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_is_write,
   input  wire logic [ctpl_pkg::ADDR_W-1:0]       req_address,
   output logic                                   rsp_valid,
   output logic                                   rsp_l1_hit,
   output logic                                   rsp_l2_read_hit,
   output logic                                   rsp_l1_writeback,
   output logic                                   rsp_prefetch_issued,
   output logic      [1:0]                        rsp_prefetch_hit_count,
   output logic      [1:0]                        rsp_prefetch_evict_count,
   input  wire logic                              csr_write_enable,
   input  wire logic [ctpl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ctpl_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int TW = ctpl_pkg::TAG_W;
   localparam int AW = ctpl_pkg::ADDR_W;

   // L1 geometry and row layout: valid, dirty, ranks, tags
   localparam int W1      = L1_MAX_WAYS;
   localparam int L1_WW   = (W1 > 1) ? $clog2(W1) : 1;
   localparam int L1_CW   = $clog2(W1 + 1);
   localparam int L1_SLOG = $clog2(L1_MAX_SETS + 1) - 1;
   localparam int L1_WLOG = $clog2(W1 + 1) - 1;
   localparam int L1_AW   = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
   localparam int L1_D_LO = W1;
   localparam int L1_R_LO = 2 * W1;
   localparam int L1_T_LO = 2 * W1 + W1 * L1_WW;
   localparam int L1_ROW  = L1_T_LO + W1 * TW;

   // L2 geometry and row layout: valid, prefetched, ranks, tags
   localparam int W2      = L2_MAX_WAYS;
   localparam int L2_WW   = (W2 > 1) ? $clog2(W2) : 1;
   localparam int L2_CW   = $clog2(W2 + 1);
   localparam int L2_SLOG = $clog2(L2_MAX_SETS + 1) - 1;
   localparam int L2_WLOG = $clog2(W2 + 1) - 1;
   localparam int L2_AW   = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
   localparam int L2_P_LO = W2;
   localparam int L2_R_LO = 2 * W2;
   localparam int L2_T_LO = 2 * W2 + W2 * L2_WW;
   localparam int L2_ROW  = L2_T_LO + W2 * TW;

   localparam int CLR_N  = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
   localparam int CLR_CW = (CLR_N > 1) ? $clog2(CLR_N) : 1;

   function automatic logic [L1_ROW-1:0] l1_reset_row();
      logic [L1_ROW-1:0] row;
      row = '0;
      for (int j = 0; j < W1; j++) begin
         row[L1_R_LO + j*L1_WW +: L1_WW] = L1_WW'(j);
      end
      return row;
   endfunction

   function automatic logic [L2_ROW-1:0] l2_reset_row();
      logic [L2_ROW-1:0] row;
      row = '0;
      for (int j = 0; j < W2; j++) begin
         row[L2_R_LO + j*L2_WW +: L2_WW] = L2_WW'(j);
      end
      return row;
   endfunction

   localparam logic [L1_ROW-1:0] L1_RESET_ROW = l1_reset_row();
   localparam logic [L2_ROW-1:0] L2_RESET_ROW = l2_reset_row();

   function automatic int fit(input int b, input int lim);
      return (b > lim) ? lim : b;
   endfunction

   function automatic logic [AW-1:0] set_field(input logic [AW-1:0] a,
                                               input logic [4:0] o,
                                               input logic [3:0] i);
      return (a >> o) & ((64'd1 << i) - 64'd1);
   endfunction

   function automatic logic [AW-1:0] tag_field(input logic [AW-1:0] a,
                                               input logic [4:0] o,
                                               input logic [3:0] i);
      return a >> ({1'b0, o} + {2'b0, i});
   endfunction

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_CHK1,
      ST_VICT,
      ST_DEM2,
      ST_PF_RD,
      ST_PF_CHK,
      ST_WB_RD,
      ST_WB_CHK,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [CLR_CW-1:0] clr_ff, clr_in;

   logic [4:0] cfg_l1_off_ff, cfg_l1_off_in;
   logic [3:0] cfg_l1_idx_ff, cfg_l1_idx_in;
   logic [1:0] cfg_l1_way_ff, cfg_l1_way_in;
   logic [4:0] cfg_l2_off_ff, cfg_l2_off_in;
   logic [3:0] cfg_l2_idx_ff, cfg_l2_idx_in;
   logic [2:0] cfg_l2_way_ff, cfg_l2_way_in;
   logic [1:0] cfg_l2_mode_ff, cfg_l2_mode_in;
   logic       cfg_pf_en_ff, cfg_pf_en_in;

   logic             wr_ff, wr_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [TW-1:0]    tag1_ff, tag1_in, tag2_ff, tag2_in;
   logic [L1_AW-1:0] set1_ff, set1_in, pset1_ff, pset1_in;
   logic [L2_AW-1:0] set2_ff, set2_in, pset2_ff, pset2_in, wset_ff, wset_in;
   logic [TW-1:0]    ptag1_ff, ptag1_in, ptag2_ff, ptag2_in, wtag_ff, wtag_in;
   logic [L1_ROW-1:0] row1_ff, row1_in;
   logic [L1_WW-1:0] vway_ff, vway_in;
   logic             vdirty_ff, vdirty_in;
   logic [AW-1:0]    wa_ff, wa_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       hit1_ff, hit1_in, hit2_ff, hit2_in, wb_ff, wb_in, pfi_ff, pfi_in;
   logic [1:0] pfh_ff, pfh_in, pfe_ff, pfe_in;

   // Effective geometry
   logic [3:0]       i1, i2;
   logic [L1_CW-1:0] w1;
   logic [L2_CW-1:0] w2;
   logic             l2on, lip;

   assign i1   = 4'(fit(int'(cfg_l1_idx_ff), L1_SLOG));
   assign i2   = 4'(fit(int'(cfg_l2_idx_ff), L2_SLOG));
   assign w1   = L1_CW'(1 << fit(int'(cfg_l1_way_ff), L1_WLOG));
   assign w2   = L2_CW'(1 << fit(int'(cfg_l2_way_ff), L2_WLOG));
   assign l2on = (cfg_l2_mode_ff != ctpl_pkg::L2_MODE_OFF);
   assign lip  = (cfg_l2_mode_ff == ctpl_pkg::L2_MODE_LIP);

   // Tag memories, one set per row
   logic              ram1_we, ram1_re;
   logic [L1_AW-1:0]  ram1_waddr, ram1_raddr;
   logic [L1_ROW-1:0] ram1_wdata, ram1_rd;
   logic              ram2_we, ram2_re;
   logic [L2_AW-1:0]  ram2_waddr, ram2_raddr;
   logic [L2_ROW-1:0] ram2_wdata, ram2_rd;

   ctpl_ram #(.WIDTH(L1_ROW), .DEPTH(L1_MAX_SETS)) u_l1_ram (
      .clock   (clock),
      .wr_en   (ram1_we),
      .wr_addr (ram1_waddr),
      .wr_data (ram1_wdata),
      .rd_en   (ram1_re),
      .rd_addr (ram1_raddr),
      .rd_data (ram1_rd)
   );

   ctpl_ram #(.WIDTH(L2_ROW), .DEPTH(L2_MAX_SETS)) u_l2_ram (
      .clock   (clock),
      .wr_en   (ram2_we),
      .wr_addr (ram2_waddr),
      .wr_data (ram2_wdata),
      .rd_en   (ram2_re),
      .rd_addr (ram2_raddr),
      .rd_data (ram2_rd)
   );

   // L1 set lookup and recency update
   ctpl_pkg::probe_status_type st1;
   logic [L1_WW-1:0]    hit_way1, lru_way1, way1;
   logic [TW-1:0]       ptag_sel1;
   logic [W1*L1_WW-1:0] rank_src1, rank_new1;

   assign ptag_sel1 = (state_ff == ST_PF_CHK) ? ptag1_ff : tag1_ff;
   assign rank_src1 = (state_ff == ST_FIN) ? row1_ff[L1_R_LO +: W1*L1_WW]
                                           : ram1_rd[L1_R_LO +: W1*L1_WW];
   assign way1      = (state_ff == ST_FIN) ? vway_ff : hit_way1;

   ctpl_set_probe #(.WAYS(W1)) u_l1_probe (
      .tags    (ram1_rd[L1_T_LO +: W1*TW]),
      .valid   (ram1_rd[W1-1:0]),
      .ranks   (ram1_rd[L1_R_LO +: W1*L1_WW]),
      .active  (w1),
      .tag     (ptag_sel1),
      .status  (st1),
      .hit_way (hit_way1),
      .inv_way (),
      .lru_way (lru_way1)
   );

   ctpl_rank_update #(.WAYS(W1)) u_l1_rank (
      .op        (ctpl_pkg::RANK_FRONT),
      .ranks_in  (rank_src1),
      .valid_in  (ram1_rd[W1-1:0]),
      .active    (w1),
      .way       (way1),
      .ranks_out (rank_new1)
   );

   // L2 set lookup and recency update
   ctpl_pkg::probe_status_type st2;
   logic [L2_WW-1:0]    hit_way2, inv_way2, lru_way2, fill_way2, way2;
   logic [TW-1:0]       tag_sel2;
   logic [W2*L2_WW-1:0] rank_new2;
   logic [W2-1:0]       valid_post2;
   logic                hit_mode2, evict2, pf_hit2;
   ctpl_pkg::rank_op_type op2;

   always_comb begin
      case (state_ff)
         ST_DEM2:   tag_sel2 = tag2_ff;
         ST_PF_CHK: tag_sel2 = ptag2_ff;
         default:   tag_sel2 = wtag_ff;
      endcase
   end

   ctpl_set_probe #(.WAYS(W2)) u_l2_probe (
      .tags    (ram2_rd[L2_T_LO +: W2*TW]),
      .valid   (ram2_rd[W2-1:0]),
      .ranks   (ram2_rd[L2_R_LO +: W2*L2_WW]),
      .active  (w2),
      .tag     (tag_sel2),
      .status  (st2),
      .hit_way (hit_way2),
      .inv_way (inv_way2),
      .lru_way (lru_way2)
   );

   assign hit_mode2   = ((state_ff == ST_DEM2) || (state_ff == ST_WB_CHK)) && st2.hit;
   assign fill_way2   = st2.inv_found ? inv_way2 : lru_way2;
   assign way2        = hit_mode2 ? hit_way2 : fill_way2;
   assign valid_post2 = ram2_rd[W2-1:0] | (hit_mode2 ? '0 : (W2'(1) << fill_way2));
   assign op2         = (!hit_mode2 && lip) ? ctpl_pkg::RANK_LIP : ctpl_pkg::RANK_FRONT;
   assign evict2      = !st2.inv_found && ram2_rd[L2_P_LO + int'(fill_way2)];
   assign pf_hit2     = ram2_rd[L2_P_LO + int'(hit_way2)];

   ctpl_rank_update #(.WAYS(W2)) u_l2_rank (
      .op        (op2),
      .ranks_in  (ram2_rd[L2_R_LO +: W2*L2_WW]),
      .valid_in  (valid_post2),
      .active    (w2),
      .way       (way2),
      .ranks_out (rank_new2)
   );

   // Updated rows
   logic [L1_ROW-1:0] row1_hit, row1_fin;
   logic [L2_ROW-1:0] row2_new;

   always_comb begin
      row1_hit = ram1_rd;
      row1_hit[L1_R_LO +: W1*L1_WW] = rank_new1;
      if (wr_ff) begin
         row1_hit[L1_D_LO + int'(hit_way1)] = 1'b1;
      end

      row1_fin = row1_ff;
      row1_fin[L1_R_LO +: W1*L1_WW]          = rank_new1;
      row1_fin[int'(vway_ff)]                = 1'b1;
      row1_fin[L1_D_LO + int'(vway_ff)]      = wr_ff;
      row1_fin[L1_T_LO + int'(vway_ff)*TW +: TW] = tag1_ff;

      row2_new = ram2_rd;
      row2_new[L2_R_LO +: W2*L2_WW] = rank_new2;
      if (hit_mode2) begin
         row2_new[L2_P_LO + int'(hit_way2)] = 1'b0;
      end else begin
         row2_new[int'(fill_way2)]                  = 1'b1;
         row2_new[L2_P_LO + int'(fill_way2)]        = (state_ff == ST_PF_CHK);
         row2_new[L2_T_LO + int'(fill_way2)*TW +: TW] = tag_sel2;
      end
   end

   // Take control register writes
   always_comb begin
      cfg_l1_off_in  = cfg_l1_off_ff;
      cfg_l1_idx_in  = cfg_l1_idx_ff;
      cfg_l1_way_in  = cfg_l1_way_ff;
      cfg_l2_off_in  = cfg_l2_off_ff;
      cfg_l2_idx_in  = cfg_l2_idx_ff;
      cfg_l2_way_in  = cfg_l2_way_ff;
      cfg_l2_mode_in = cfg_l2_mode_ff;
      cfg_pf_en_in   = cfg_pf_en_ff;
      if (csr_write_enable) begin
         case (ctpl_pkg::csr_index_type'(csr_index))
            ctpl_pkg::CSR_L1_OFFSET:   cfg_l1_off_in  = csr_write_data[4:0];
            ctpl_pkg::CSR_L1_INDEX:    cfg_l1_idx_in  = csr_write_data[3:0];
            ctpl_pkg::CSR_L1_WAYS:     cfg_l1_way_in  = csr_write_data[1:0];
            ctpl_pkg::CSR_L2_OFFSET:   cfg_l2_off_in  = csr_write_data[4:0];
            ctpl_pkg::CSR_L2_INDEX:    cfg_l2_idx_in  = csr_write_data[3:0];
            ctpl_pkg::CSR_L2_WAYS:     cfg_l2_way_in  = csr_write_data[2:0];
            ctpl_pkg::CSR_L2_MODE:     cfg_l2_mode_in = csr_write_data[1:0];
            ctpl_pkg::CSR_L2_PREFETCH: cfg_pf_en_in   = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sequence the set lookups of one item
   logic [AW-1:0] nx;
   logic [AW-1:0] wa_c;

   assign nx   = addr_ff + (64'd1 << cfg_l2_off_ff);
   assign wa_c = (ram1_rd[L1_T_LO + int'(lru_way1)*TW +: TW] << ({1'b0, cfg_l1_off_ff} + {2'b0, i1}))
               | (AW'(set1_ff) << cfg_l1_off_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wr_in        = wr_ff;
      addr_in      = addr_ff;
      tag1_in      = tag1_ff;
      set1_in      = set1_ff;
      tag2_in      = tag2_ff;
      set2_in      = set2_ff;
      ptag1_in     = ptag1_ff;
      pset1_in     = pset1_ff;
      ptag2_in     = ptag2_ff;
      pset2_in     = pset2_ff;
      wtag_in      = wtag_ff;
      wset_in      = wset_ff;
      row1_in      = row1_ff;
      vway_in      = vway_ff;
      vdirty_in    = vdirty_ff;
      wa_in        = wa_ff;
      hit1_in      = hit1_ff;
      hit2_in      = hit2_ff;
      wb_in        = wb_ff;
      pfi_in       = pfi_ff;
      pfh_in       = pfh_ff;
      pfe_in       = pfe_ff;
      rsp_valid_in = 1'b0;
      ram1_we      = 1'b0;
      ram1_waddr   = set1_ff;
      ram1_wdata   = row1_fin;
      ram1_re      = 1'b0;
      ram1_raddr   = pset1_ff;
      ram2_we      = 1'b0;
      ram2_waddr   = set2_ff;
      ram2_wdata   = row2_new;
      ram2_re      = 1'b0;
      ram2_raddr   = pset2_ff;

      case (state_ff)
         ST_CLR: begin
            ram1_we    = (int'(clr_ff) < L1_MAX_SETS);
            ram1_waddr = clr_ff[L1_AW-1:0];
            ram1_wdata = L1_RESET_ROW;
            ram2_we    = (int'(clr_ff) < L2_MAX_SETS);
            ram2_waddr = clr_ff[L2_AW-1:0];
            ram2_wdata = L2_RESET_ROW;
            clr_in     = clr_ff + CLR_CW'(1);
            if (int'(clr_ff) == CLR_N - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               wr_in      = req_is_write;
               addr_in    = req_address;
               set1_in    = L1_AW'(set_field(req_address, cfg_l1_off_ff, i1));
               tag1_in    = tag_field(req_address, cfg_l1_off_ff, i1);
               set2_in    = L2_AW'(set_field(req_address, cfg_l2_off_ff, i2));
               tag2_in    = tag_field(req_address, cfg_l2_off_ff, i2);
               ram1_re    = 1'b1;
               ram1_raddr = set1_in;
               ram2_re    = 1'b1;
               ram2_raddr = set2_in;
               hit1_in    = 1'b0;
               hit2_in    = 1'b0;
               wb_in      = 1'b0;
               pfi_in     = 1'b0;
               pfh_in     = '0;
               pfe_in     = '0;
               state_in   = ST_CHK1;
            end
         end
         ST_CHK1: begin
            if (st1.hit) begin
               ram1_we      = 1'b1;
               ram1_wdata   = row1_hit;
               hit1_in      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               row1_in  = ram1_rd;
               state_in = ST_VICT;
            end
         end
         ST_VICT: begin
            vway_in   = lru_way1;
            vdirty_in = ram1_rd[int'(lru_way1)] && ram1_rd[L1_D_LO + int'(lru_way1)];
            wa_in     = wa_c;
            state_in  = l2on ? ST_DEM2 : ST_WB_RD;
         end
         ST_DEM2: begin
            ram2_we = 1'b1;
            if (st2.hit) begin
               hit2_in  = 1'b1;
               pfh_in   = pfh_ff + 2'(pf_hit2);
               state_in = ST_WB_RD;
            end else begin
               pfe_in = pfe_ff + 2'(evict2);
               if (cfg_pf_en_ff) begin
                  pset1_in = L1_AW'(set_field(nx, cfg_l1_off_ff, i1));
                  ptag1_in = tag_field(nx, cfg_l1_off_ff, i1);
                  pset2_in = L2_AW'(set_field(nx, cfg_l2_off_ff, i2));
                  ptag2_in = tag_field(nx, cfg_l2_off_ff, i2);
                  state_in = ST_PF_RD;
               end else begin
                  state_in = ST_WB_RD;
               end
            end
         end
         ST_PF_RD: begin
            ram1_re  = 1'b1;
            ram2_re  = 1'b1;
            state_in = ST_PF_CHK;
         end
         ST_PF_CHK: begin
            if (!st1.hit && !st2.hit) begin
               ram2_we    = 1'b1;
               ram2_waddr = pset2_ff;
               pfi_in     = 1'b1;
               pfe_in     = pfe_ff + 2'(evict2);
            end
            state_in = ST_WB_RD;
         end
         ST_WB_RD: begin
            wb_in = vdirty_ff;
            if (vdirty_ff && l2on) begin
               wset_in    = L2_AW'(set_field(wa_ff, cfg_l2_off_ff, i2));
               wtag_in    = tag_field(wa_ff, cfg_l2_off_ff, i2);
               ram2_re    = 1'b1;
               ram2_raddr = wset_in;
               state_in   = ST_WB_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WB_CHK: begin
            if (st2.hit) begin
               ram2_we    = 1'b1;
               ram2_waddr = wset_ff;
               pfh_in     = pfh_ff + 2'(pf_hit2);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            ram1_we      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, control registers and the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         cfg_l1_off_ff  <= 5'd6;
         cfg_l1_idx_ff  <= 4'd3;
         cfg_l1_way_ff  <= 2'd1;
         cfg_l2_off_ff  <= 5'd6;
         cfg_l2_idx_ff  <= 4'd5;
         cfg_l2_way_ff  <= 3'd2;
         cfg_l2_mode_ff <= ctpl_pkg::L2_MODE_OFF;
         cfg_pf_en_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_l1_off_ff  <= cfg_l1_off_in;
         cfg_l1_idx_ff  <= cfg_l1_idx_in;
         cfg_l1_way_ff  <= cfg_l1_way_in;
         cfg_l2_off_ff  <= cfg_l2_off_in;
         cfg_l2_idx_ff  <= cfg_l2_idx_in;
         cfg_l2_way_ff  <= cfg_l2_way_in;
         cfg_l2_mode_ff <= cfg_l2_mode_in;
         cfg_pf_en_ff   <= cfg_pf_en_in;
      end
      wr_ff     <= wr_in;
      addr_ff   <= addr_in;
      tag1_ff   <= tag1_in;
      set1_ff   <= set1_in;
      tag2_ff   <= tag2_in;
      set2_ff   <= set2_in;
      ptag1_ff  <= ptag1_in;
      pset1_ff  <= pset1_in;
      ptag2_ff  <= ptag2_in;
      pset2_ff  <= pset2_in;
      wtag_ff   <= wtag_in;
      wset_ff   <= wset_in;
      row1_ff   <= row1_in;
      vway_ff   <= vway_in;
      vdirty_ff <= vdirty_in;
      wa_ff     <= wa_in;
      hit1_ff   <= hit1_in;
      hit2_ff   <= hit2_in;
      wb_ff     <= wb_in;
      pfi_ff    <= pfi_in;
      pfh_ff    <= pfh_in;
      pfe_ff    <= pfe_in;
   end

   assign busy                     = (state_ff != ST_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_l1_hit               = hit1_ff;
   assign rsp_l2_read_hit          = hit2_ff;
   assign rsp_l1_writeback         = wb_ff;
   assign rsp_prefetch_issued      = pfi_ff;
   assign rsp_prefetch_hit_count   = pfh_ff;
   assign rsp_prefetch_evict_count = pfe_ff;

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without an item in flight");

   a_done_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid || $past(state_ff == ST_CLR)))
      else $error("item finished without a response");

   a_hit_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_l1_hit) |-> (!rsp_l2_read_hit && !rsp_l1_writeback &&
         !rsp_prefetch_issued && rsp_prefetch_hit_count == 2'd0 &&
         rsp_prefetch_evict_count == 2'd0))
      else $error("L1 hit reported with other events");

   a_l2_off_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !l2on) |-> (!rsp_l2_read_hit && !rsp_prefetch_issued))
      else $error("L2 event reported with L2 off");
`endif

endmodule

`default_nettype wire
